/* design/gpvu_pkg.sv */
// Shared types and constants of the gravity pair velocity update block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package gpvu_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [63:0] GRAVITY_RESET   = 64'd1231191000;
    localparam logic [31:0] TIME_STEP_RESET = 32'd1092;

    localparam logic CFG_GRAVITY   = 1'b0;
    localparam logic CFG_TIME_STEP = 1'b1;

    localparam int MAG_W = 35;
    localparam logic [MAG_W-1:0] MAG_CAP = 35'h4_0000_0000;

    typedef struct packed {
        logic signed [31:0] attractor_x;
        logic signed [31:0] attractor_y;
        logic [31:0]        attractor_mass;
        logic signed [31:0] body_x;
        logic signed [31:0] body_y;
        logic signed [31:0] velocity_in_x;
        logic signed [31:0] velocity_in_y;
        logic               same_body;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] velocity_out_x;
        logic signed [31:0] velocity_out_y;
        logic               coincident;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic        coin;
        logic        neg_x;
        logic        neg_y;
        logic [32:0] abs_x;
        logic [32:0] abs_y;
        logic [31:0] mass;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
    } work_t;

endpackage
`default_nettype wire

/* design/gpvu_front.sv */
// Front end: forms the position differences of a request and classifies it.
// Depends on gpvu_pkg.
`default_nettype none
module gpvu_front (
    input  wire gpvu_pkg::in_item_t in_data,
    output gpvu_pkg::work_t         work
);

    logic signed [32:0] dx;
    logic signed [32:0] dy;

    assign dx = {in_data.attractor_x[31], in_data.attractor_x}
              - {in_data.body_x[31], in_data.body_x};
    assign dy = {in_data.attractor_y[31], in_data.attractor_y}
              - {in_data.body_y[31], in_data.body_y};

    always_comb begin
        work.coin  = in_data.same_body || (dx == 33'sd0 && dy == 33'sd0);
        work.neg_x = dx[32];
        work.neg_y = dy[32];
        work.abs_x = dx[32] ? 33'(-dx) : 33'(dx);
        work.abs_y = dy[32] ? 33'(-dy) : 33'(dy);
        work.mass  = in_data.attractor_mass;
        work.vel_x = in_data.velocity_in_x;
        work.vel_y = in_data.velocity_in_y;
    end

endmodule
`default_nettype wire

/* design/gpvu_queue.sv */
// Short queue between the front end and the back end.
// Depends on gpvu_pkg.
`default_nettype none
module gpvu_queue #(
    parameter int DEPTH = gpvu_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire gpvu_pkg::work_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output logic                 empty,
    output gpvu_pkg::work_t      head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    gpvu_pkg::work_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* design/gpvu_back.sv */
// Back end: bit-serial square root, products and divisions of one request,
// then the saturating velocity kick into the output register. Depends on gpvu_pkg.
`default_nettype none
module gpvu_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [63:0]     gravity,
    input  wire logic [31:0]     time_step,
    input  wire logic            q_empty,
    input  wire gpvu_pkg::work_t q_head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output gpvu_pkg::out_item_t  m_data
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SQ   = 7'b0000010,
        ST_PA   = 7'b0000100,
        ST_PB   = 7'b0001000,
        ST_PC   = 7'b0010000,
        ST_PD   = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    localparam logic [5:0] LAST_MUL = 6'd32;
    localparam logic [5:0] LAST_DIV = 6'd34;

    state_t              state_reg;
    logic [5:0]          cnt_reg;
    gpvu_pkg::work_t     item_reg;
    logic [65:0]         s_reg;
    logic [65:0]         ssh_reg;
    logic [32:0]         root_reg;
    logic [35:0]         srem_reg;
    logic [32:0]         opa_reg;
    logic [32:0]         opb_reg;
    logic [95:0]         k1_reg;
    logic [127:0]        k_reg;
    logic [98:0]         den_reg;
    logic [167:0]        numx_reg;
    logic [167:0]        numy_reg;
    logic [167:0]        dsh_reg;
    logic [33:0]         qx_reg;
    logic [33:0]         qy_reg;
    logic                capx_reg;
    logic                capy_reg;
    logic                out_valid_reg;
    gpvu_pkg::out_item_t out_reg;

    logic [65:0]  s_next;
    logic [35:0]  rem2;
    logic [35:0]  trial;
    logic         root_ge;
    logic [35:0]  srem_next;
    logic [32:0]  root_next;
    logic [95:0]  k1_next;
    logic [127:0] k_next;
    logic [98:0]  den_next;
    logic [167:0] numx_next;
    logic [167:0] numy_next;
    logic         gex;
    logic         gey;
    logic [gpvu_pkg::MAG_W-1:0] magx;
    logic [gpvu_pkg::MAG_W-1:0] magy;
    logic signed [36:0] sumx;
    logic signed [36:0] sumy;
    logic         satx;
    logic         saty;
    logic [31:0]  resx;
    logic [31:0]  resy;
    logic         out_free;
    logic         load_pass;
    logic         load_fin;

    assign s_next = 66'(item_reg.abs_x) * 66'(item_reg.abs_x)
                  + 66'(item_reg.abs_y) * 66'(item_reg.abs_y);

    assign rem2      = {srem_reg[33:0], ssh_reg[65:64]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign root_ge   = (rem2 >= trial);
    assign srem_next = root_ge ? rem2 - trial : rem2;
    assign root_next = {root_reg[31:0], root_ge};

    assign k1_next   = {k1_reg[94:0], 1'b0} + (opa_reg[32] ? {32'b0, gravity} : 96'b0);
    assign k_next    = {k_reg[126:0], 1'b0} + (opa_reg[32] ? {32'b0, k1_reg} : 128'b0);
    assign den_next  = {den_reg[97:0], 1'b0} + (opb_reg[32] ? {33'b0, s_reg} : 99'b0);
    assign numx_next = {numx_reg[166:0], 1'b0} + (opa_reg[32] ? {40'b0, k_reg} : 168'b0);
    assign numy_next = {numy_reg[166:0], 1'b0} + (opb_reg[32] ? {40'b0, k_reg} : 168'b0);

    assign gex = (numx_reg >= dsh_reg);
    assign gey = (numy_reg >= dsh_reg);

    assign magx = capx_reg ? gpvu_pkg::MAG_CAP : {1'b0, qx_reg};
    assign magy = capy_reg ? gpvu_pkg::MAG_CAP : {1'b0, qy_reg};

    always_comb begin
        logic signed [36:0] vx_e;
        logic signed [36:0] vy_e;
        logic signed [36:0] mx_e;
        logic signed [36:0] my_e;
        vx_e = {{5{item_reg.vel_x[31]}}, item_reg.vel_x};
        vy_e = {{5{item_reg.vel_y[31]}}, item_reg.vel_y};
        mx_e = {2'b0, magx};
        my_e = {2'b0, magy};
        sumx = item_reg.neg_x ? vx_e - mx_e : vx_e + mx_e;
        sumy = item_reg.neg_y ? vy_e - my_e : vy_e + my_e;
        satx = !((sumx[36:31] == 6'b000000) || (sumx[36:31] == 6'b111111));
        saty = !((sumy[36:31] == 6'b000000) || (sumy[36:31] == 6'b111111));
        resx = satx ? (sumx[36] ? 32'h8000_0000 : 32'h7fff_ffff) : sumx[31:0];
        resy = saty ? (sumy[36] ? 32'h8000_0000 : 32'h7fff_ffff) : sumy[31:0];
    end

    assign out_free  = !out_valid_reg || m_ready;
    assign load_pass = (state_reg == ST_IDLE) && !q_empty && q_head.coin && out_free;
    assign load_fin  = (state_reg == ST_FIN) && out_free;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty && (!q_head.coin || out_free);

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (load_pass) begin
            out_reg.velocity_out_x <= q_head.vel_x;
            out_reg.velocity_out_y <= q_head.vel_y;
            out_reg.coincident     <= 1'b1;
            out_reg.saturated      <= 1'b0;
        end else if (load_fin) begin
            out_reg.velocity_out_x <= resx;
            out_reg.velocity_out_y <= resy;
            out_reg.coincident     <= 1'b0;
            out_reg.saturated      <= satx || saty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_pass || load_fin) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    item_reg <= q_head;
                end
            end
            ST_SQ: begin
                s_reg    <= s_next;
                ssh_reg  <= s_next;
                root_reg <= '0;
                srem_reg <= '0;
                k1_reg   <= '0;
                opa_reg  <= {1'b0, item_reg.mass};
            end
            ST_PA: begin
                ssh_reg  <= {ssh_reg[63:0], 2'b00};
                root_reg <= root_next;
                srem_reg <= srem_next;
                k1_reg   <= k1_next;
                if (cnt_reg == LAST_MUL) begin
                    opa_reg <= {1'b0, time_step};
                    opb_reg <= root_next;
                    k_reg   <= '0;
                    den_reg <= '0;
                end else begin
                    opa_reg <= {opa_reg[31:0], 1'b0};
                end
            end
            ST_PB: begin
                k_reg   <= k_next;
                den_reg <= den_next;
                if (cnt_reg == LAST_MUL) begin
                    opa_reg  <= item_reg.abs_x;
                    opb_reg  <= item_reg.abs_y;
                    numx_reg <= '0;
                    numy_reg <= '0;
                end else begin
                    opa_reg <= {opa_reg[31:0], 1'b0};
                    opb_reg <= {opb_reg[31:0], 1'b0};
                end
            end
            ST_PC: begin
                numx_reg <= numx_next;
                numy_reg <= numy_next;
                opa_reg  <= {opa_reg[31:0], 1'b0};
                opb_reg  <= {opb_reg[31:0], 1'b0};
                if (cnt_reg == LAST_MUL) begin
                    dsh_reg <= {3'b0, den_reg, 66'b0};
                end
            end
            ST_PD: begin
                dsh_reg <= {1'b0, dsh_reg[167:1]};
                if (cnt_reg == 6'd0) begin
                    capx_reg <= gex;
                    capy_reg <= gey;
                    qx_reg   <= '0;
                    qy_reg   <= '0;
                end else begin
                    if (gex) begin
                        numx_reg <= numx_reg - dsh_reg;
                    end
                    if (gey) begin
                        numy_reg <= numy_reg - dsh_reg;
                    end
                    qx_reg <= {qx_reg[32:0], gex};
                    qy_reg <= {qy_reg[32:0], gey};
                end
            end
            ST_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                    if (q_pop && !q_head.coin) begin
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_PA;
                end
                ST_PA, ST_PB, ST_PC: begin
                    if (cnt_reg == LAST_MUL) begin
                        cnt_reg   <= '0;
                        state_reg <= (state_reg == ST_PA) ? ST_PB :
                                     (state_reg == ST_PB) ? ST_PC : ST_PD;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_PD: begin
                    if (cnt_reg == LAST_DIV) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_FIN;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* design/gravity_pair_velocity_update.sv */
// Gravity pair velocity update: one request carries an attractor and a body, and one
// result carries the body's velocity after one gravity kick. A same-body or
// coincident request keeps its velocity and is passed on by the idle back end; any
// other request occupies the shared bit-serial back end (square root, three product
// passes, quotient digits) while the front end and queue take requests until full.
// Depends on gpvu_pkg, gpvu_front, gpvu_queue and gpvu_back.
`default_nettype none
module gravity_pair_velocity_update #(
    parameter int QUEUE_DEPTH = gpvu_pkg::QUEUE_DEPTH
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [63:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire gpvu_pkg::in_item_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output gpvu_pkg::out_item_t     m_data
);

    logic [63:0]     gravity_reg;
    logic [31:0]     time_step_reg;
    gpvu_pkg::work_t front_work;
    gpvu_pkg::work_t q_head;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    logic            push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg   <= gpvu_pkg::GRAVITY_RESET;
            time_step_reg <= gpvu_pkg::TIME_STEP_RESET;
        end else if (cfg_we) begin
            if (cfg_index == gpvu_pkg::CFG_GRAVITY) begin
                gravity_reg <= cfg_wdata;
            end else if (cfg_index == gpvu_pkg::CFG_TIME_STEP) begin
                time_step_reg <= cfg_wdata[31:0];
            end
        end
    end

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    gpvu_front u_front (
        .in_data (s_data),
        .work    (front_work)
    );

    gpvu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_work),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    gpvu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gravity   (gravity_reg),
        .time_step (time_step_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_coin_not_sat : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.coincident |-> !m_data.saturated)
        else $error("A coincident result reports saturation.");

    a_sat_clamped : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            (m_data.velocity_out_x == 32'sh7fff_ffff
             || m_data.velocity_out_x == 32'sh8000_0000
             || m_data.velocity_out_y == 32'sh7fff_ffff
             || m_data.velocity_out_y == 32'sh8000_0000))
        else $error("A saturated result carries no clamped component.");

    a_no_pop_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("The back end took a request from an empty queue.");

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for gravity_pair_velocity_update: random and directed pair
// requests, with the expected velocities worked out from exact wide-integer arithmetic.
// Depends on gpvu_pkg and the block's RTL.
`timescale 1ns / 1ps
module testbench;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = gpvu_pkg::CFG_GRAVITY;
    logic [63:0]         cfg_wdata = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    gpvu_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    gpvu_pkg::out_item_t m_data;

    logic [63:0]         gravity_now = gpvu_pkg::GRAVITY_RESET;
    logic [31:0]         step_now = gpvu_pkg::TIME_STEP_RESET;
    gpvu_pkg::in_item_t  pending_pairs[$];
    gpvu_pkg::out_item_t expected_velocities[$];
    int                  idle_pct = 33;
    bit                  failed = 1'b0;

    gravity_pair_velocity_update DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic signed [31:0] apply_kick(logic signed [31:0] vel,
            logic [gpvu_pkg::MAG_W-1:0] mag, bit neg, inout bit sat);
        longint sum;
        longint change;
        change = longint'(mag);
        sum = neg ? longint'(vel) - change : longint'(vel) + change;
        if (sum > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (sum < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return sum[31:0];
    endfunction

    function automatic logic [gpvu_pkg::MAG_W-1:0] capped(logic [255:0] q);
        return (q > 256'(gpvu_pkg::MAG_CAP)) ? gpvu_pkg::MAG_CAP : q[gpvu_pkg::MAG_W-1:0];
    endfunction

    function automatic gpvu_pkg::out_item_t predict_velocity(gpvu_pkg::in_item_t p);
        logic signed [32:0]  dx, dy;
        logic [32:0]         ax, ay;
        logic [65:0]         dist_sq;
        logic [67:0]         rem, trial;
        logic [33:0]         root;
        logic [255:0]        k, den;
        bit                  sat;
        gpvu_pkg::out_item_t r;
        dx = 33'(p.attractor_x) - 33'(p.body_x);
        dy = 33'(p.attractor_y) - 33'(p.body_y);
        ax = dx[32] ? -dx : dx;
        ay = dy[32] ? -dy : dy;
        dist_sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
        sat = 1'b0;
        r.velocity_out_x = p.velocity_in_x;
        r.velocity_out_y = p.velocity_in_y;
        r.coincident = p.same_body || dist_sq == 0;
        if (!r.coincident) begin
            root = '0;
            rem = '0;
            for (int i = 32; i >= 0; i--) begin
                rem = (rem << 2) | 68'((dist_sq >> (2 * i)) & 66'd3);
                trial = 68'({root, 2'b01});
                if (rem >= trial) begin
                    rem = rem - trial;
                    root = {root[32:0], 1'b1};
                end else begin
                    root = {root[32:0], 1'b0};
                end
            end
            k = 256'(gravity_now) * 256'(p.attractor_mass) * 256'(step_now);
            den = (256'(dist_sq) * 256'(root)) << 32;
            r.velocity_out_x = apply_kick(p.velocity_in_x, capped((k * 256'(ax)) / den),
                                          dx[32], sat);
            r.velocity_out_y = apply_kick(p.velocity_in_y, capped((k * 256'(ay)) / den),
                                          dy[32], sat);
        end
        r.saturated = sat;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_velocities.push_back(predict_velocity(s_data));
            if (!s_valid || s_ready) begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_valid <= 1'b1;
                    s_data <= pending_pairs.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= $urandom_range(99) >= idle_pct;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_velocities.size() == 0) begin
                $display("%0t: unexpected result, actual %p", $time, m_data);
                failed = 1'b1;
            end else begin
                gpvu_pkg::out_item_t e;
                e = expected_velocities.pop_front();
                if (m_data.velocity_out_x !== e.velocity_out_x) begin
                    $display("%0t: velocity_out_x expected %0d actual %0d", $time,
                             e.velocity_out_x, m_data.velocity_out_x);
                    failed = 1'b1;
                end
                if (m_data.velocity_out_y !== e.velocity_out_y) begin
                    $display("%0t: velocity_out_y expected %0d actual %0d", $time,
                             e.velocity_out_y, m_data.velocity_out_y);
                    failed = 1'b1;
                end
                if (m_data.coincident !== e.coincident) begin
                    $display("%0t: coincident expected %0b actual %0b", $time,
                             e.coincident, m_data.coincident);
                    failed = 1'b1;
                end
                if (m_data.saturated !== e.saturated) begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             e.saturated, m_data.saturated);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic write_register(logic index, logic [63:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (index == gpvu_pkg::CFG_GRAVITY)
            gravity_now = value;
        else
            step_now = value[31:0];
    endtask

    task automatic drain_requests();
        while (pending_pairs.size() != 0 || s_valid || expected_velocities.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic gpvu_pkg::in_item_t make_pair(logic signed [31:0] axp,
            logic signed [31:0] ayp, logic [31:0] mass, logic signed [31:0] bxp,
            logic signed [31:0] byp, logic signed [31:0] vx, logic signed [31:0] vy,
            logic same);
        gpvu_pkg::in_item_t p;
        p.attractor_x = axp;
        p.attractor_y = ayp;
        p.attractor_mass = mass;
        p.body_x = bxp;
        p.body_y = byp;
        p.velocity_in_x = vx;
        p.velocity_in_y = vy;
        p.same_body = same;
        return p;
    endfunction

    function automatic gpvu_pkg::in_item_t random_pair();
        gpvu_pkg::in_item_t p;
        p = gpvu_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, 1'(($urandom_range(19) == 0))});
        case ($urandom_range(3))
            0: ;
            1: begin
                p.body_x = p.attractor_x + $signed($urandom_range(512)) - 256;
                p.body_y = p.attractor_y + $signed($urandom_range(512)) - 256;
            end
            2: begin
                p.body_x = p.attractor_x + $signed($urandom_range(1 << 20)) - (1 << 19);
                p.body_y = p.attractor_y + $signed($urandom_range(1 << 20)) - (1 << 19);
            end
            default: begin
                p.body_x = p.attractor_x + $signed($urandom_range(4)) - 2;
                p.body_y = p.attractor_y;
            end
        endcase
        return p;
    endfunction

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            pending_pairs.push_back(random_pair());
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        pending_pairs.push_back(make_pair(100, 200, 5, 100, 200, 7, -7, 1'b1));
        pending_pairs.push_back(make_pair(0, 0, 32'hFFFFFFFF, 0, 0, 1, 2, 1'b0));
        pending_pairs.push_back(make_pair(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'hFFFFFFFF,
                                          32'sh80000000, 32'sh80000000, 0, 0, 1'b0));
        pending_pairs.push_back(make_pair(32'sh80000000, 32'sh7FFFFFFF, 1000,
                                          32'sh7FFFFFFF, 32'sh80000000,
                                          32'sh7FFFFFFF, 32'sh80000000, 1'b0));
        pending_pairs.push_back(make_pair(1, 0, 32'hFFFFFFFF, 0, 0,
                                          32'sh7FFFFFF0, 0, 1'b0));
        pending_pairs.push_back(make_pair(0, -1, 32'hFFFFFFFF, 0, 0,
                                          0, 32'sh80000010, 1'b0));
        pending_pairs.push_back(make_pair(65536, 65536, 0, 0, 0, 5, 5, 1'b0));
        pending_pairs.push_back(make_pair(3, 4, 1 << 20, 0, 0, -100, 100, 1'b0));
        pending_pairs.push_back(make_pair(-65536, 0, 32'h00FF00FF, 0, 0, 0, 0, 1'b0));
        pending_pairs.push_back(make_pair(0, 0, 1, 0, 0, 32'sh80000000, 32'sh7FFFFFFF, 1'b1));
        drain_requests();

        write_register(gpvu_pkg::CFG_GRAVITY, 64'hFFFFFFFFFFFFFFFF);
        write_register(gpvu_pkg::CFG_TIME_STEP, 32'hFFFFFFFF);
        pending_pairs.push_back(make_pair(65536, 0, 1, 0, 0, 0, 0, 1'b0));
        pending_pairs.push_back(make_pair(32'sh7FFFFFFF, 0, 1, 32'sh80000000, 0, 0, 0, 1'b0));
        queue_random(100);
        drain_requests();

        write_register(gpvu_pkg::CFG_GRAVITY, 64'd0);
        write_register(gpvu_pkg::CFG_TIME_STEP, 32'd65536);
        queue_random(60);
        drain_requests();

        write_register(gpvu_pkg::CFG_GRAVITY, gpvu_pkg::GRAVITY_RESET);
        write_register(gpvu_pkg::CFG_TIME_STEP, 32'd0);
        queue_random(60);
        drain_requests();

        idle_pct = 0;
        write_register(gpvu_pkg::CFG_TIME_STEP, gpvu_pkg::TIME_STEP_RESET);
        queue_random(150);
        drain_requests();

        idle_pct = 33;
        for (int phase = 0; phase < 4; phase++) begin
            write_register(gpvu_pkg::CFG_GRAVITY, {$urandom, $urandom} >> $urandom_range(40));
            write_register(gpvu_pkg::CFG_TIME_STEP, $urandom >> $urandom_range(24));
            queue_random(70);
            drain_requests();
        end

        repeat (200) @(posedge aclk);
        if (!failed) begin
            $display("** gravity_pair_velocity_update: PASSED **");
        end else begin
            $display("** gravity_pair_velocity_update: FAILED **");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("** gravity_pair_velocity_update: FAILED **");
        $finish;
    end
endmodule

/* sim.f */
design/gpvu_pkg.sv
design/gpvu_front.sv
design/gpvu_queue.sv
design/gpvu_back.sv
design/gravity_pair_velocity_update.sv
bench/testbench.sv
